// ----- sv/vic_pkg.sv -----
// ----------------------------------------------------------------------------
// vic_pkg
// Types and constants shared by the interrupt controller modules.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int unsigned NSRC = 64;
  localparam int unsigned NPW = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LEVEL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register indexes.
  localparam logic [9:0] R_CTRL  = 10'd0;
  localparam logic [9:0] R_PMASK = 10'd1;
  localparam logic [9:0] R_ENSET = 10'd2;
  localparam logic [9:0] R_ENCLR = 10'd3;
  localparam logic [9:0] R_ENH   = 10'd4;
  localparam logic [9:0] R_ENL   = 10'd5;
  localparam logic [9:0] R_FTH   = 10'd6;
  localparam logic [9:0] R_FTL   = 10'd7;
  localparam logic [9:0] R_NVEC  = 10'd16;
  localparam logic [9:0] R_FVEC  = 10'd17;
  localparam logic [9:0] R_PNDH  = 10'd18;
  localparam logic [9:0] R_PNDL  = 10'd19;
  localparam logic [9:0] R_FRCH  = 10'd20;
  localparam logic [9:0] R_FRCL  = 10'd21;
  localparam logic [9:0] R_NPH   = 10'd22;
  localparam logic [9:0] R_NPL   = 10'd23;
  localparam logic [9:0] R_FPH   = 10'd24;
  localparam logic [9:0] R_FPL   = 10'd25;
  localparam logic [9:0] R_VER   = 10'd64;

  localparam logic [31:0] CTRL_WMASK = 32'h017C_0000;
  localparam logic [31:0] VER_VALUE  = 32'h0000_0004;
  localparam logic [4:0]  PM_NONE    = 5'h1f;

  typedef struct packed {
    op_t         op;
    logic [9:0]  reg_index;
    logic [31:0] write_data;
    logic [5:0]  source_num;
    logic        source_level;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        fiq_out;
  } res_t;

endpackage

// ----- sv/vic_if.sv -----
// ----------------------------------------------------------------------------
// vic_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface vic_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/vectored_interrupt_controller_top.sv -----
// ----------------------------------------------------------------------------
// vectored_interrupt_controller_top
// Interrupt controller for 64 sources with a word-indexed register map.
// ----------------------------------------------------------------------------
// The in_ channel carries one transaction per bus read, bus write or source
// level change; the out_ channel returns one result per transaction with the
// read data and the normal and fast line levels after it.
// A two-entry queue takes transactions while the back end works. The back end
// scans the sources eight per cycle, over all 64 sources.
// A read or a level change is popped, scanned and then finished; a write is
// popped, executed and then scanned. A vector read that clears a pending bit
// needs a second scan after the finish. Transactions run one at a time, so the
// next one is popped only after the result is taken.
// Reset clears all masks and priorities and sets the priority mask to 0x1f.
// When the receiver stalls, the result is held on out_ and the queue fills,
// after which in_ready falls.
module vectored_interrupt_controller_top (
  input  logic clk,
  input  logic rst_n,
  vic_if.sink   in_ch,
  vic_if.source out_ch
);
  import vic_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  vic_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_ch.data),
    .q_valid, .q_pop, .q_item
  );

  vic_back u_back (
    .clk, .rst_n,
    .q_valid, .q_pop, .q_item,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.data = res;

  // A pop only happens when the queue holds a transaction.
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // A popped transaction yields no result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> !out_ch.valid)
    else $error("result too early");
endmodule

// ----- sv/vic_front.sv -----
// ----------------------------------------------------------------------------
// vic_front
// Two-entry queue that accepts transactions and hands them to the back end.
// ----------------------------------------------------------------------------
module vic_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vic_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output vic_pkg::item_t q_item
);
  import vic_pkg::*;

  item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ----- sv/vic_back.sv -----
// ----------------------------------------------------------------------------
// vic_back
// Holds the controller state, executes transactions and scans the sources
// eight per cycle for the vectors and the normal and fast lines.
// ----------------------------------------------------------------------------
module vic_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  vic_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vic_pkg::res_t  out_res
);
  import vic_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;

  state_t      state_r;
  logic [63:0] pend_r, en_r, ft_r;
  logic [31:0] ctrl_r;
  logic [4:0]  pml_r;
  logic [31:0] pw_r [NPW];
  item_t       it_r;
  logic [2:0]  grp_r;
  // Scan results: best normal source, lowest fast source, line hit.
  logic        nf_r, ff_r, hit_r;
  logic [5:0]  nbest_r, fbest_r;
  logic [3:0]  nprio_r;
  res_t        res_r;

  logic [63:0] nrm, fst;
  logic [31:0] rd;
  logic [7:0]  gn, gf;
  logic [31:0] gw;
  logic        c_nf, c_ff, c_hit;
  logic [5:0]  c_nb, c_fb;
  logic [3:0]  c_np;

  assign nrm = pend_r & en_r & ~ft_r;
  assign fst = pend_r & en_r & ft_r;
  assign gn  = nrm[{grp_r, 3'b000} +: 8];
  assign gf  = fst[{grp_r, 3'b000} +: 8];
  assign gw  = pw_r[grp_r];

  // One scan step over a group of eight sources, upward in number.
  always_comb begin
    c_nf  = nf_r;
    c_ff  = ff_r;
    c_hit = hit_r;
    c_nb  = nbest_r;
    c_fb  = fbest_r;
    c_np  = nprio_r;
    for (int k = 0; k < 8; k++) begin
      if (gn[k]) begin
        if (!c_nf || gw[4*k +: 4] >= c_np) begin
          c_nf = 1'b1;
          c_np = gw[4*k +: 4];
          c_nb = {grp_r, 3'(k)};
        end
        if ({1'b0, gw[4*k +: 4]} > pml_r) c_hit = 1'b1;
      end
      if (gf[k] && !c_ff) begin
        c_ff = 1'b1;
        c_fb = {grp_r, 3'(k)};
      end
    end
  end

  // Read data for the current transaction.
  always_comb begin
    rd = 32'd0;
    unique case (it_r.reg_index)
      R_CTRL:  rd = ctrl_r;
      R_PMASK: rd = {27'd0, pml_r};
      R_ENH:   rd = en_r[63:32];
      R_ENL:   rd = en_r[31:0];
      R_FTH:   rd = ft_r[63:32];
      R_FTL:   rd = ft_r[31:0];
      R_NVEC:  rd = nf_r ? {10'd0, nbest_r, 12'd0, nprio_r} : '1;
      R_FVEC:  rd = ff_r ? {26'd0, fbest_r} : '1;
      R_PNDH:  rd = pend_r[63:32];
      R_PNDL:  rd = pend_r[31:0];
      R_NPH:   rd = nrm[63:32];
      R_NPL:   rd = nrm[31:0];
      R_FPH:   rd = fst[63:32];
      R_FPL:   rd = fst[31:0];
      R_VER:   rd = VER_VALUE;
      default: begin
        if (it_r.reg_index[9:3] == 7'd1) rd = pw_r[3'(~it_r.reg_index[2:0])];
      end
    endcase
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_res   = res_r;

  // Sequencer: execute writes, scan to find vectors and lines, then deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= '0;
      en_r    <= '0;
      ft_r    <= '0;
      ctrl_r  <= '0;
      pml_r   <= PM_NONE;
      for (int i = 0; i < NPW; i++) pw_r[i] <= '0;
      grp_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            // A level change is applied before the scan.
            if (q_item.op == OP_LEVEL) pend_r[q_item.source_num] <= q_item.source_level;
            grp_r   <= '0;
            nf_r    <= 1'b0;
            ff_r    <= 1'b0;
            hit_r   <= 1'b0;
            nbest_r <= '0;
            fbest_r <= '0;
            nprio_r <= '0;
            state_r <= (q_item.op == OP_WRITE) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          nf_r    <= c_nf;
          ff_r    <= c_ff;
          hit_r   <= c_hit;
          nbest_r <= c_nb;
          fbest_r <= c_fb;
          nprio_r <= c_np;
          grp_r   <= grp_r + 3'd1;
          if (grp_r == 3'd7) begin
            state_r <= S_FIN;
            if (it_r.op == OP_WRITE) begin
              // Post-write scan done: lines are final, read data already set.
              res_r.irq_out <= c_nf && (pml_r == PM_NONE || c_hit);
              res_r.fiq_out <= c_ff;
              state_r <= S_OUT;
            end
          end
        end
        S_FIN: begin
          if (it_r.op == OP_WRITE) begin
            unique case (it_r.reg_index)
              R_CTRL:  ctrl_r <= it_r.write_data & CTRL_WMASK;
              R_PMASK: pml_r <= it_r.write_data[4:0];
              R_ENSET: en_r[it_r.write_data[5:0]] <= 1'b1;
              R_ENCLR: en_r[it_r.write_data[5:0]] <= 1'b0;
              R_ENH:   en_r[63:32] <= it_r.write_data;
              R_ENL:   en_r[31:0] <= it_r.write_data;
              R_FTH:   ft_r[63:32] <= it_r.write_data;
              R_FTL:   ft_r[31:0] <= it_r.write_data;
              R_FRCH:  pend_r[63:32] <= it_r.write_data;
              R_FRCL:  pend_r[31:0] <= it_r.write_data;
              default: begin
                if (it_r.reg_index[9:3] == 7'd1)
                  pw_r[3'(~it_r.reg_index[2:0])] <= it_r.write_data;
              end
            endcase
            res_r.read_data <= 32'd0;
            grp_r   <= '0;
            nf_r    <= 1'b0;
            ff_r    <= 1'b0;
            hit_r   <= 1'b0;
            nprio_r <= '0;
            state_r <= S_SCAN;
          end else if (it_r.op == OP_READ &&
                       ((it_r.reg_index == R_NVEC && nf_r) ||
                        (it_r.reg_index == R_FVEC && ff_r))) begin
            // Vector read clears the chosen pending bit, then rescans lines.
            pend_r[(it_r.reg_index == R_NVEC) ? nbest_r : fbest_r] <= 1'b0;
            res_r.read_data <= rd;
            it_r.op  <= OP_WRITE;
            it_r.reg_index <= R_NVEC;
            grp_r   <= '0;
            nf_r    <= 1'b0;
            ff_r    <= 1'b0;
            hit_r   <= 1'b0;
            nprio_r <= '0;
            state_r <= S_SCAN;
          end else begin
            res_r   <= '{read_data: (it_r.op == OP_READ) ? rd : 32'd0,
                         irq_out: nf_r && (pml_r == PM_NONE || hit_r),
                         fiq_out: ff_r};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
